@@ src/spv_pkg.sv @@
// Shared types and constants for the store path name validator.
package spv_pkg;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_TOO_SHORT  = 3'd1,
    VERDICT_BAD_HASH   = 3'd2,
    VERDICT_EMPTY_NAME = 3'd3,
    VERDICT_NAME_LONG  = 3'd4,
    VERDICT_DOT_NAME   = 3'd5,
    VERDICT_DOT_DASH   = 3'd6,
    VERDICT_BAD_CHAR   = 3'd7
  } verdict_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [7:0]       fault_char;
    logic [CNT_W-1:0] fault_position;
    logic [CNT_W-1:0] total_length;
  } result_t;

endpackage

@@ src/store_path_name_validator.sv @@
// Top level of the store path name validator: input register, check logic, result register.
//
// Bytes of one string enter on the item channel, one transaction per byte, and the
// byte flagged last_byte produces exactly one verdict transaction on the result
// channel. The block takes one byte every clock cycle while no last byte waits in the
// input register. A verdict is offered once its last byte has left the input register
// and the check logic has loaded the result register. Only a last byte waits
// in the input register, and only while the previous verdict is still stalled in the
// result register; other bytes pass through regardless. name_only is written through
// the cfg port, which is always ready, and should change only while no byte is waiting
// in the input register.
module store_path_name_validator #(
  parameter int HASH_CHARS = 32,
  parameter int MAX_NAME   = 211
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  spv_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output spv_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  logic             name_only;
  logic             stage_valid;
  spv_pkg::item_t   stage;
  logic             advance;
  logic             fire;
  spv_pkg::result_t verdict_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      name_only <= cfg_data;
    end
  end

  // A staged byte that yields no verdict never has to wait.
  assign advance    = !(stage.last_byte && result_valid && result_stall);
  assign fire       = stage_valid && advance;
  assign item_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage <= item;
    end
  end

  spv_core #(
    .HASH_CHARS(HASH_CHARS),
    .MAX_NAME  (MAX_NAME)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (stage),
    .name_only(name_only),
    .result   (verdict_data)
  );

  spv_result_reg u_result_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (fire && stage.last_byte),
    .data        (verdict_data),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

@@ src/spv_core.sv @@
// Per-string state and the combinational byte check and verdict logic.
module spv_core #(
  parameter int HASH_CHARS = 32,
  parameter int MAX_NAME   = 211
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  spv_pkg::item_t   item,
  input  logic             name_only,
  output spv_pkg::result_t result
);

  localparam int CW = spv_pkg::CNT_W;
  localparam logic [CW-1:0] HASH_LIM = CW'(HASH_CHARS);
  localparam logic [CW-1:0] OFF_FULL = CW'(HASH_CHARS + 1);
  localparam logic [CW-1:0] MAX_LEN  = CW'(MAX_NAME);
  localparam logic [7:0] CHAR_DOT  = 8'h2e;
  localparam logic [7:0] CHAR_DASH = 8'h2d;

  logic [CW-1:0]      byte_count;
  logic [2:0][7:0]    name_head;
  logic               hash_fault_seen;
  logic [7:0]         hash_fault_byte;
  logic [CW-1:0]      hash_fault_pos;
  logic               name_fault_seen;
  logic [7:0]         name_fault_byte;
  logic [CW-1:0]      name_fault_pos;

  logic [CW-1:0]      count;
  logic [CW-1:0]      off;
  logic [CW-1:0]      ni;
  logic [CW-1:0]      nlen;
  logic               hash_zone;
  logic               name_zone;
  logic [2:0][7:0]    name_head_next;
  logic               hash_fault_seen_next;
  logic [7:0]         hash_fault_byte_next;
  logic [CW-1:0]      hash_fault_pos_next;
  logic               name_fault_seen_next;
  logic [7:0]         name_fault_byte_next;
  logic [CW-1:0]      name_fault_pos_next;

  function automatic logic is_hash_digit(input logic [7:0] c);
    logic digit;
    logic lower;
    digit = (c >= "0") && (c <= "9");
    lower = (c >= "a") && (c <= "z") && (c != "e") && (c != "o") && (c != "u") && (c != "t");
    return digit || lower;
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    logic alnum;
    logic punct;
    alnum = ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z")) ||
            ((c >= "A") && (c <= "Z"));
    punct = (c == "+") || (c == "-") || (c == ".") || (c == "_") || (c == "?") || (c == "=");
    return alnum || punct;
  endfunction

  always_comb begin
    count     = (byte_count == spv_pkg::COUNT_MAX) ? byte_count : byte_count + 1'b1;
    off       = name_only ? '0 : OFF_FULL;
    hash_zone = !name_only && (byte_count < HASH_LIM);
    name_zone = !hash_zone && (byte_count >= off);
    ni        = byte_count - off;

    name_head_next       = name_head;
    hash_fault_seen_next = hash_fault_seen;
    hash_fault_byte_next = hash_fault_byte;
    hash_fault_pos_next  = hash_fault_pos;
    name_fault_seen_next = name_fault_seen;
    name_fault_byte_next = name_fault_byte;
    name_fault_pos_next  = name_fault_pos;

    if (hash_zone && !is_hash_digit(item.char_byte) && !hash_fault_seen) begin
      hash_fault_seen_next = 1'b1;
      hash_fault_byte_next = item.char_byte;
      hash_fault_pos_next  = byte_count;
    end
    if (name_zone) begin
      if (ni < CW'(3)) begin
        name_head_next[ni[1:0]] = item.char_byte;
      end
      if (!is_name_char(item.char_byte) && !name_fault_seen) begin
        name_fault_seen_next = 1'b1;
        name_fault_byte_next = item.char_byte;
        name_fault_pos_next  = byte_count;
      end
    end

    nlen = (count >= off) ? count - off : '0;

    // Checks are ranked; the first one that fails sets the verdict.
    result.fault_char     = '0;
    result.fault_position = '0;
    result.total_length   = count;
    if (!name_only && (count < OFF_FULL)) begin
      result.verdict = spv_pkg::VERDICT_TOO_SHORT;
    end else if (!name_only && hash_fault_seen_next) begin
      result.verdict        = spv_pkg::VERDICT_BAD_HASH;
      result.fault_char     = hash_fault_byte_next;
      result.fault_position = hash_fault_pos_next;
    end else if (nlen == '0) begin
      result.verdict = spv_pkg::VERDICT_EMPTY_NAME;
    end else if (nlen > MAX_LEN) begin
      result.verdict = spv_pkg::VERDICT_NAME_LONG;
    end else if (name_head_next[0] == CHAR_DOT && nlen == CW'(1)) begin
      result.verdict = spv_pkg::VERDICT_DOT_NAME;
    end else if (name_head_next[0] == CHAR_DOT && name_head_next[1] == CHAR_DASH) begin
      result.verdict = spv_pkg::VERDICT_DOT_DASH;
    end else if (name_head_next[0] == CHAR_DOT && name_head_next[1] == CHAR_DOT &&
                 nlen == CW'(2)) begin
      result.verdict = spv_pkg::VERDICT_DOT_NAME;
    end else if (name_head_next[0] == CHAR_DOT && name_head_next[1] == CHAR_DOT &&
                 nlen >= CW'(3) && name_head_next[2] == CHAR_DASH) begin
      result.verdict = spv_pkg::VERDICT_DOT_DASH;
    end else if (name_fault_seen_next) begin
      result.verdict        = spv_pkg::VERDICT_BAD_CHAR;
      result.fault_char     = name_fault_byte_next;
      result.fault_position = name_fault_pos_next;
    end else begin
      result.verdict = spv_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last_byte)) begin
      byte_count      <= '0;
      name_head       <= '0;
      hash_fault_seen <= 1'b0;
      hash_fault_byte <= '0;
      hash_fault_pos  <= '0;
      name_fault_seen <= 1'b0;
      name_fault_byte <= '0;
      name_fault_pos  <= '0;
    end else if (fire) begin
      byte_count      <= count;
      name_head       <= name_head_next;
      hash_fault_seen <= hash_fault_seen_next;
      hash_fault_byte <= hash_fault_byte_next;
      hash_fault_pos  <= hash_fault_pos_next;
      name_fault_seen <= name_fault_seen_next;
      name_fault_byte <= name_fault_byte_next;
      name_fault_pos  <= name_fault_pos_next;
    end
  end

endmodule

@@ src/spv_result_reg.sv @@
// Output register holding one verdict until the downstream side takes it.
module spv_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  spv_pkg::result_t data,
  input  logic             result_stall,
  output logic             result_valid,
  output spv_pkg::result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= data;
    end
  end

endmodule

@@ src/spv_checker.sv @@
// Port-level checks for the store path name validator, bound to the top level.
module spv_checker #(
  parameter int HASH_CHARS = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input spv_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input spv_pkg::result_t result,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             cfg_data
);

  localparam logic [spv_pkg::CNT_W-1:0] OFF_FULL = spv_pkg::CNT_W'(HASH_CHARS + 1);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transaction changed or vanished");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.verdict != spv_pkg::VERDICT_BAD_HASH &&
    result.verdict != spv_pkg::VERDICT_BAD_CHAR |->
    result.fault_char == '0 && result.fault_position == '0)
    else $error("fault fields set on a verdict without an offending byte");

  a_too_short_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.verdict == spv_pkg::VERDICT_TOO_SHORT |->
    result.total_length < OFF_FULL)
    else $error("too-short verdict on a string long enough for the hash");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled while no verdict transaction is blocked");

endmodule

bind store_path_name_validator spv_checker #(.HASH_CHARS(HASH_CHARS)) u_spv_checker (.*);
